### rtl/ansi_truecolor_ascii_pixel_encoder_macros.svh
// assertion macros used by the checker file
`ifndef ANSI_TRUECOLOR_ASCII_PIXEL_ENCODER_MACROS_SVH
`define ANSI_TRUECOLOR_ASCII_PIXEL_ENCODER_MACROS_SVH

// checked only outside reset
`define ATAPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ATAPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/atape_pkg.sv
package atape_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] GLYPH_TABLE_RESET = 64'h4057_336E_2A3D_2D20;

  // register index, taken from paddr[3]
  localparam logic REG_GLYPH_TABLE = 1'b0;

  // one color component split into decimal digits
  typedef struct packed {
    logic       has_h;
    logic       has_t;
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
  } dec_t;

  // classified pixel, front to back
  typedef struct packed {
    logic       need_esc;
    dec_t       r;
    dec_t       g;
    dec_t       b;
    logic [7:0] glyph;
    logic       row_end;
  } entry_t;

  function automatic dec_t dec_split(input logic [7:0] v);
    dec_t        d;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [3:0]  tens;
    d.has_h = (v >= 8'd100);
    d.has_t = (v >= 8'd10);
    if (v >= 8'd200) begin
      d.h = 4'd2;
      rem = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      d.h = 4'd1;
      rem = 7'(v - 8'd100);
    end else begin
      d.h = 4'd0;
      rem = v[6:0];
    end
    // rem < 100, so x*205>>11 is exactly x/10
    tprod = 15'(rem) * 15'd205;
    tens = tprod[14:11];
    d.t = tens;
    d.o = 4'(rem - 7'(7'(tens) * 7'd10));
    return d;
  endfunction

endpackage

### rtl/atape_front.sv
module atape_front #(
  parameter int GLYPH_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            gray_level,
  input  logic                  row_end,
  input  logic [63:0]           glyph_table,
  input  logic                  q_full,
  output logic                  q_wr,
  output atape_pkg::entry_t     q_entry
);
  import atape_pkg::*;

  logic [23:0] previous_color;
  logic [23:0] color;
  logic [31:0] gray_scaled;
  logic [2:0]  level;
  logic        accept;

  assign color       = {red, green, blue};
  assign accept      = push && !q_full;
  assign gray_scaled = 32'(gray_level) * 32'(GLYPH_COUNT);
  assign level       = gray_scaled[10:8];

  always_comb begin
    q_entry.need_esc = (color != previous_color);
    q_entry.r        = dec_split(red);
    q_entry.g        = dec_split(green);
    q_entry.b        = dec_split(blue);
    q_entry.glyph    = glyph_table[{level, 3'b000} +: 8];
    q_entry.row_end  = row_end;
  end

  assign q_wr = accept;

  // color as the terminal will have it once this beat's bytes are out
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_color <= '0;
    end else if (accept) begin
      previous_color <= color;
    end
  end

endmodule

### rtl/atape_queue.sv
module atape_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  atape_pkg::entry_t wr_entry,
  output logic              full,
  input  logic              rd,
  output logic              rd_valid,
  output atape_pkg::entry_t rd_entry
);
  import atape_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/atape_back.sv
module atape_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  atape_pkg::entry_t q_entry,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              run_last
);
  import atape_pkg::*;

  // byte positions of one run
  localparam logic [4:0] S_ESC   = 5'd0;
  localparam logic [4:0] S_LBR   = 5'd1;
  localparam logic [4:0] S_3     = 5'd2;
  localparam logic [4:0] S_8     = 5'd3;
  localparam logic [4:0] S_SEMI0 = 5'd4;
  localparam logic [4:0] S_2     = 5'd5;
  localparam logic [4:0] S_SEMI1 = 5'd6;
  localparam logic [4:0] S_RH    = 5'd7;
  localparam logic [4:0] S_RT    = 5'd8;
  localparam logic [4:0] S_RO    = 5'd9;
  localparam logic [4:0] S_SEMI2 = 5'd10;
  localparam logic [4:0] S_GH    = 5'd11;
  localparam logic [4:0] S_GT    = 5'd12;
  localparam logic [4:0] S_GO    = 5'd13;
  localparam logic [4:0] S_SEMI3 = 5'd14;
  localparam logic [4:0] S_BH    = 5'd15;
  localparam logic [4:0] S_BT    = 5'd16;
  localparam logic [4:0] S_BO    = 5'd17;
  localparam logic [4:0] S_M     = 5'd18;
  localparam logic [4:0] S_GLYPH = 5'd19;
  localparam logic [4:0] S_NL    = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  logic [4:0] slot;
  logic       mid;
  logic [4:0] cur;
  logic [4:0] nxt;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       advance;
  logic       ov;
  logic [7:0] ob;
  logic       ol;

  function automatic logic [4:0] first_digit(input dec_t d, input logic [4:0] sh,
                                             input logic [4:0] st, input logic [4:0] so);
    return d.has_h ? sh : (d.has_t ? st : so);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CH_ZERO + 8'(d);
  endfunction

  assign cur = mid ? slot : (q_entry.need_esc ? S_ESC : S_GLYPH);

  always_comb begin
    case (cur)
      S_ESC, S_LBR, S_3, S_8, S_SEMI0, S_2: nxt = cur + 5'd1;
      S_SEMI1: nxt = first_digit(q_entry.r, S_RH, S_RT, S_RO);
      S_RH:    nxt = S_RT;
      S_RT:    nxt = S_RO;
      S_RO:    nxt = S_SEMI2;
      S_SEMI2: nxt = first_digit(q_entry.g, S_GH, S_GT, S_GO);
      S_GH:    nxt = S_GT;
      S_GT:    nxt = S_GO;
      S_GO:    nxt = S_SEMI3;
      S_SEMI3: nxt = first_digit(q_entry.b, S_BH, S_BT, S_BO);
      S_BH:    nxt = S_BT;
      S_BT:    nxt = S_BO;
      S_BO:    nxt = S_M;
      S_M:     nxt = S_GLYPH;
      S_GLYPH: nxt = q_entry.row_end ? S_NL : S_DONE;
      default: nxt = S_DONE;
    endcase
  end

  always_comb begin
    case (cur)
      S_ESC:   cur_byte = CH_ESC;
      S_LBR:   cur_byte = CH_LBR;
      S_3:     cur_byte = digit_char(4'd3);
      S_8:     cur_byte = digit_char(4'd8);
      S_2:     cur_byte = digit_char(4'd2);
      S_SEMI0, S_SEMI1, S_SEMI2, S_SEMI3: cur_byte = CH_SEMI;
      S_RH:    cur_byte = digit_char(q_entry.r.h);
      S_RT:    cur_byte = digit_char(q_entry.r.t);
      S_RO:    cur_byte = digit_char(q_entry.r.o);
      S_GH:    cur_byte = digit_char(q_entry.g.h);
      S_GT:    cur_byte = digit_char(q_entry.g.t);
      S_GO:    cur_byte = digit_char(q_entry.g.o);
      S_BH:    cur_byte = digit_char(q_entry.b.h);
      S_BT:    cur_byte = digit_char(q_entry.b.t);
      S_BO:    cur_byte = digit_char(q_entry.b.o);
      S_M:     cur_byte = CH_M;
      S_GLYPH: cur_byte = q_entry.glyph;
      default: cur_byte = CH_NL;
    endcase
  end

  assign cur_last = (nxt == S_DONE);
  assign advance  = q_valid && (!ov || pop);
  assign q_rd     = advance && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid  <= 1'b0;
      slot <= S_ESC;
    end else if (advance) begin
      mid  <= !cur_last;
      slot <= nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance) begin
      ov <= 1'b1;
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob <= cur_byte;
      ol <= cur_last;
    end
  end

  assign empty    = !ov;
  assign out_byte = ob;
  assign run_last = ol;

endmodule

### rtl/ansi_truecolor_ascii_pixel_encoder.sv
// truecolor ascii-art encoder: pixels in, terminal text bytes out
// input channel: one pixel per beat (red, green, blue, gray_level, row_end),
//   taken at a clock edge with push high and full low
// output channel: one text byte per beat (out_byte, run_last), offered while
//   empty is low and taken at an edge with pop high; run_last marks the final
//   byte of the run a pixel causes
// a pixel whose color differs from the last emitted one produces the escape
//   ESC[38;2;R;G;Bm (decimal, no leading zeros), then its glyph, then a newline
//   when row_end is set: 1 to 21 bytes per pixel
// with queue and output idle, a taken pixel is written to a queue slot and its
//   first byte then passes through the output register before it is offered
// throughput: while pop keeps up, the output side moves one byte per cycle;
//   repeated colors without row_end run at one pixel per cycle
// a 4-entry queue sits between the classifier and the byte sequencer; while
//   pop is held low the output byte holds, the queue fills and full rises
// reset: queue and output empty, last color black, glyph table back to " -=*n3W@"
// config: glyph_table at byte address 0 over a 64-bit apb port; write it only
//   while no pixel is in flight
module ansi_truecolor_ascii_pixel_encoder #(
  parameter int GLYPH_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  // pixel channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  gray_level,
  input  logic        row_end,
  // byte channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import atape_pkg::*;

  logic [63:0] glyph_table;
  logic        cfg_wr;
  logic        q_wr;
  logic        q_full;
  entry_t      front_entry;
  logic        q_rd;
  logic        q_valid;
  entry_t      head_entry;

  // register file: one 64-bit register, index in paddr[3]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_GLYPH_TABLE);
  assign prdata = (paddr[3] == REG_GLYPH_TABLE) ? glyph_table : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_table <= GLYPH_TABLE_RESET;
    end else if (cfg_wr) begin
      glyph_table <= pwdata;
    end
  end

  // front: color compare, digit split, glyph pick
  atape_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .gray_level  (gray_level),
    .row_end     (row_end),
    .glyph_table (glyph_table),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_entry     (front_entry)
  );

  assign full = q_full;

  // decoupling queue
  atape_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (front_entry),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_entry (head_entry)
  );

  // back: walks the byte positions of the head entry, one byte per cycle while pop keeps up
  atape_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (head_entry),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .run_last (run_last)
  );

endmodule

### rtl/atape_checker.sv
`include "ansi_truecolor_ascii_pixel_encoder_macros.svh"

module atape_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic        run_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready
);
  import atape_pkg::*;

  // a stalled byte stays put
  `ATAPE_ASSERT(a_out_hold,
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(run_last),
    "output beat changed while stalled")

  // reset leaves both sides idle
  `ATAPE_ASSERT_ALWAYS(a_reset_idle, rst |=> empty && !full, "not idle after reset")

  // glyph table write reads back next cycle
  `ATAPE_ASSERT(a_cfg_readback,
    psel && penable && pwrite && pready && paddr[3] == REG_GLYPH_TABLE
      |=> paddr[3] != REG_GLYPH_TABLE || prdata == $past(pwdata),
    "glyph table readback mismatch")

endmodule

bind ansi_truecolor_ascii_pixel_encoder atape_checker u_atape_checker (.*);
